FILE: rtl/core/cws_pkg.sv
// ----------------------------------------------------------------------------
// cws_pkg
// Shared types and constants for the comment and whitespace skipper.
// ----------------------------------------------------------------------------
package cws_pkg;

  localparam int POS_BITS = 16;
  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
  localparam logic [POS_BITS-1:0] POS_ONE = {{(POS_BITS-1){1'b0}}, 1'b1};

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;

  typedef enum logic [2:0] {
    MODE_NORMAL     = 3'd0,
    MODE_SLASH      = 3'd1,
    MODE_LINE       = 3'd2,
    MODE_BLOCK      = 3'd3,
    MODE_BLOCK_STAR = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    KIND_CHAR   = 2'd0,
    KIND_STRAY  = 2'd1,
    KIND_UNTERM = 2'd2
  } kind_t;

  typedef struct packed {
    mode_t                mode_nxt;
    logic [POS_BITS-1:0]  line_nxt;
    logic [POS_BITS-1:0]  col_nxt;
    logic                 emit;
    kind_t                kind;
    logic [7:0]           ch;
    logic [POS_BITS-1:0]  line;
    logic [POS_BITS-1:0]  col;
  } step_t;

endpackage

FILE: rtl/core/comment_whitespace_skipper_core.sv
// ----------------------------------------------------------------------------
// comment_whitespace_skipper_core
// Drops whitespace and C comments from a stream and reports the remaining
// characters, stray slashes and unterminated comments with line and column.
//
//   channel | dir | handshake          | payload
//   in_     | in  | in_valid/in_stall  | char_in, end_of_stream
//   out_    | out | out_valid/out_stall| kind, char_out, line_no, column_no
//
// One request per cycle while out_stall is low, passing the input register,
// then the result register. The mode and position registers update when the
// held request passes through the step logic into the result register.
// Reset: mode normal, line and column 1, both stages empty.
// out_stall holds the result register; the input register then fills and
// in_stall rises.
// ----------------------------------------------------------------------------
module comment_whitespace_skipper_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_char_in,
  input  logic                          in_end_of_stream,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_kind,
  output logic [7:0]                    out_char_out,
  output logic [cws_pkg::POS_BITS-1:0]  out_line_no,
  output logic [cws_pkg::POS_BITS-1:0]  out_column_no
);
  import cws_pkg::*;

  logic                 s1_valid_r, s1_valid_nxt;
  logic [7:0]           s1_ch_r;
  logic                 s1_eos_r;
  mode_t                mode_r;
  logic [POS_BITS-1:0]  line_r;
  logic [POS_BITS-1:0]  col_r;
  logic                 out_valid_r, out_valid_nxt;
  kind_t                out_kind_r;
  logic [7:0]           out_ch_r;
  logic [POS_BITS-1:0]  out_line_r;
  logic [POS_BITS-1:0]  out_col_r;
  step_t                step;
  logic                 adv;
  logic                 take;

  cws_step u_step (
    .mode (mode_r),
    .line (line_r),
    .col  (col_r),
    .ch   (s1_ch_r),
    .eos  (s1_eos_r),
    .step (step)
  );

  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign take     = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = take ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
    if (adv)                          out_valid_nxt = step.emit;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    else                              out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      mode_r      <= MODE_NORMAL;
      line_r      <= POS_ONE;
      col_r       <= POS_ONE;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        mode_r <= step.mode_nxt;
        line_r <= step.line_nxt;
        col_r  <= step.col_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_ch_r  <= in_char_in;
      s1_eos_r <= in_end_of_stream;
    end
    if (adv && step.emit) begin
      out_kind_r <= step.kind;
      out_ch_r   <= step.ch;
      out_line_r <= step.line;
      out_col_r  <= step.col;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_char_out  = out_ch_r;
  assign out_line_no   = out_line_r;
  assign out_column_no = out_col_r;

endmodule

FILE: rtl/core/cws_step.sv
// ----------------------------------------------------------------------------
// cws_step
// Mode transition, position update and result selection for one character.
// ----------------------------------------------------------------------------
module cws_step (
  input  cws_pkg::mode_t                 mode,
  input  logic [cws_pkg::POS_BITS-1:0]   line,
  input  logic [cws_pkg::POS_BITS-1:0]   col,
  input  logic [7:0]                     ch,
  input  logic                           eos,
  output cws_pkg::step_t                 step
);
  import cws_pkg::*;

  logic is_nl;
  logic is_ws;

  assign is_nl = (ch == CH_NL);
  assign is_ws = is_nl || (ch == CH_TAB) || (ch == CH_SPACE);

  always_comb begin
    step          = '0;
    step.mode_nxt = MODE_NORMAL;
    step.line_nxt = line;
    step.col_nxt  = col;
    step.kind     = KIND_CHAR;
    step.ch       = ch;
    step.line     = line;
    step.col      = col;
    step.emit     = 1'b0;

    if (eos) begin
      step.ch = 8'h00;
      case (mode)
        MODE_BLOCK, MODE_BLOCK_STAR: begin
          step.emit = 1'b1;
          step.kind = KIND_UNTERM;
        end
        MODE_SLASH: begin
          step.emit = 1'b1;
          step.kind = KIND_STRAY;
        end
        default: begin
          step.emit = 1'b0;
        end
      endcase
    end else begin
      if (is_nl) begin
        if (line != POS_MAX) step.line_nxt = line + POS_ONE;
        step.col_nxt = POS_ONE;
      end else if (col != POS_MAX) begin
        step.col_nxt = col + POS_ONE;
      end

      case (mode)
        MODE_SLASH: begin
          if (ch == CH_SLASH) begin
            step.mode_nxt = MODE_LINE;
          end else if (ch == CH_STAR) begin
            step.mode_nxt = MODE_BLOCK;
          end else begin
            step.emit = 1'b1;
            step.kind = KIND_STRAY;
          end
        end
        MODE_LINE: begin
          step.mode_nxt = is_nl ? MODE_NORMAL : MODE_LINE;
        end
        MODE_BLOCK: begin
          step.mode_nxt = (ch == CH_STAR) ? MODE_BLOCK_STAR : MODE_BLOCK;
        end
        MODE_BLOCK_STAR: begin
          if (ch == CH_SLASH)     step.mode_nxt = MODE_NORMAL;
          else if (ch == CH_STAR) step.mode_nxt = MODE_BLOCK_STAR;
          else                    step.mode_nxt = MODE_BLOCK;
        end
        default: begin
          if (ch == CH_SLASH) begin
            step.mode_nxt = MODE_SLASH;
          end else if (!is_ws) begin
            step.emit = 1'b1;
          end
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/cws_checker.sv
// ----------------------------------------------------------------------------
// cws_checker
// Port-level checks for comment_whitespace_skipper_core.
// ----------------------------------------------------------------------------
module cws_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [7:0]                    in_char_in,
  input logic                          in_end_of_stream,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [1:0]                    out_kind,
  input logic [7:0]                    out_char_out,
  input logic [cws_pkg::POS_BITS-1:0]  out_line_no,
  input logic [cws_pkg::POS_BITS-1:0]  out_column_no
);
  import cws_pkg::*;

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_char_in) &&
      $stable(in_end_of_stream))
    else $error("stalled request changed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) &&
      $stable(out_char_out) && $stable(out_line_no) && $stable(out_column_no))
    else $error("stalled result changed");

  a_visible: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_CHAR |->
      out_char_out != CH_SPACE && out_char_out != CH_TAB &&
      out_char_out != CH_NL && out_char_out != CH_SLASH)
    else $error("dropped character reported as visible");

  a_unterm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_UNTERM |-> out_char_out == 8'h00)
    else $error("unterminated comment with nonzero character");

  a_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_line_no != '0 && out_column_no != '0 &&
      out_kind != 2'd3)
    else $error("bad position or kind");

endmodule

bind comment_whitespace_skipper_core cws_checker u_cws_checker (.*);

FILE: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for comment_whitespace_skipper_core. Character requests
// are sent from named tests: directed cases, random source text, well-formed
// or not, and a pause that drains the block.
// An in-bench scanner predicts every result, and each accepted result is
// compared in order against it; both sides idle at random in most phases.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cws_pkg::*;

  typedef struct {
    kind_t               kind;
    logic [7:0]          ch;
    logic [POS_BITS-1:0] line;
    logic [POS_BITS-1:0] col;
  } report_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [7:0]          in_char_in = 8'h00;
  logic                in_end_of_stream = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [1:0]          out_kind;
  logic [7:0]          out_char_out;
  logic [POS_BITS-1:0] out_line_no;
  logic [POS_BITS-1:0] out_column_no;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int sent_count = 0;
  int mismatch_count = 0;

  mode_t               text_mode = MODE_NORMAL;
  logic [POS_BITS-1:0] pos_line = POS_ONE;
  logic [POS_BITS-1:0] pos_col = POS_ONE;
  report_t             expected_tokens[$];
  report_t             head_token;

  comment_whitespace_skipper_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_in       (in_char_in),
    .in_end_of_stream (in_end_of_stream),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_char_out     (out_char_out),
    .out_line_no      (out_line_no),
    .out_column_no    (out_column_no)
  );

  always #2 clk = ~clk;

  initial begin
    #8_000_000;
    $display("testbench failed");
    $finish;
  end

  // scanner: position update, mode transition, optional report
  function automatic void advance_scanner(input logic [7:0] ch, input logic eos);
    report_t r;
    logic    hit;
    mode_t   mode;
    mode = text_mode;
    hit = 1'b0;
    r.kind = KIND_CHAR;
    r.ch = ch;
    r.line = pos_line;
    r.col = pos_col;
    if (eos) begin
      text_mode = MODE_NORMAL;
      r.ch = 8'h00;
      if (mode == MODE_BLOCK || mode == MODE_BLOCK_STAR) begin
        r.kind = KIND_UNTERM;
        hit = 1'b1;
      end else if (mode == MODE_SLASH) begin
        r.kind = KIND_STRAY;
        hit = 1'b1;
      end
    end else begin
      if (ch == CH_NL) begin
        if (pos_line != POS_MAX) pos_line = pos_line + POS_ONE;
        pos_col = POS_ONE;
      end else if (pos_col != POS_MAX) begin
        pos_col = pos_col + POS_ONE;
      end
      case (mode)
        MODE_SLASH: begin
          if (ch == CH_SLASH) begin
            text_mode = MODE_LINE;
          end else if (ch == CH_STAR) begin
            text_mode = MODE_BLOCK;
          end else begin
            text_mode = MODE_NORMAL;
            r.kind = KIND_STRAY;
            hit = 1'b1;
          end
        end
        MODE_LINE: begin
          if (ch == CH_NL) text_mode = MODE_NORMAL;
        end
        MODE_BLOCK: begin
          if (ch == CH_STAR) text_mode = MODE_BLOCK_STAR;
        end
        MODE_BLOCK_STAR: begin
          if (ch == CH_SLASH) text_mode = MODE_NORMAL;
          else if (ch != CH_STAR) text_mode = MODE_BLOCK;
        end
        default: begin
          text_mode = MODE_NORMAL;
          if (ch == CH_SLASH) begin
            text_mode = MODE_SLASH;
          end else if (ch != CH_SPACE && ch != CH_TAB && ch != CH_NL) begin
            hit = 1'b1;
          end
        end
      endcase
    end
    if (hit) expected_tokens.push_back(r);
  endfunction

  function automatic logic [7:0] pick_plain();
    logic [7:0] c;
    do c = 8'($urandom);
    while (c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_SLASH);
    return c;
  endfunction

  function automatic logic [7:0] pick_space();
    case ($urandom_range(2))
      0: return CH_SPACE;
      1: return CH_TAB;
      default: return CH_NL;
    endcase
  endfunction

  function automatic logic [7:0] pick_not_newline();
    logic [7:0] c;
    do c = 8'($urandom);
    while (c == CH_NL);
    return c;
  endfunction

  task automatic send_request(input logic [7:0] ch, input logic eos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_in <= ch;
    in_end_of_stream <= eos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_scanner(ch, eos);
    sent_count++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_request(s[i], 1'b0);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_token();
    int         pick;
    int         n;
    logic [7:0] c;
    pick = $urandom_range(99);
    n = $urandom_range(1, 6);
    if (pick < 35) begin
      repeat (n) send_request(pick_plain(), 1'b0);
    end else if (pick < 52) begin
      repeat (n / 2 + 1) send_request(pick_space(), 1'b0);
    end else if (pick < 67) begin
      send_text("//");
      repeat ($urandom_range(0, 8)) send_request(pick_not_newline(), 1'b0);
      if ($urandom_range(9) == 0) send_request(8'($urandom), 1'b1);
      else send_request(CH_NL, 1'b0);
    end else if (pick < 84) begin
      send_text("/*");
      repeat ($urandom_range(0, 10)) begin
        if ($urandom_range(3) == 0) send_request(CH_STAR, 1'b0);
        else send_request(8'($urandom), 1'b0);
      end
      if ($urandom_range(7) == 0) begin
        send_request(8'($urandom), 1'b1);
      end else begin
        repeat ($urandom_range(1, 3)) send_request(CH_STAR, 1'b0);
        send_request(CH_SLASH, 1'b0);
      end
    end else if (pick < 92) begin
      send_request(CH_SLASH, 1'b0);
      if ($urandom_range(6) == 0) begin
        send_request(8'($urandom), 1'b1);
      end else begin
        do c = 8'($urandom);
        while (c == CH_SLASH || c == CH_STAR);
        send_request(c, 1'b0);
      end
    end else if (pick < 95) begin
      send_request(8'($urandom), 1'b1);
    end else begin
      repeat (n) send_request(8'($urandom), $urandom_range(9) == 0);
    end
  endtask

  task automatic test_visible_extremes();
    send_request(8'h00, 1'b0);
    send_request(8'hFF, 1'b0);
    send_request(CH_STAR, 1'b0);
  endtask

  task automatic test_whitespace();
    send_text(" \t\n");
  endtask

  // opening star must not close the block; star run must
  task automatic test_comments();
    send_text("//\n/*/**/");
  endtask

  task automatic test_stray_slash_and_end();
    send_text("/q");
    send_request(CH_SLASH, 1'b0);
    send_request(8'hFF, 1'b1);
    send_text("/**");
    send_request(8'hFF, 1'b1);
    send_request(8'h00, 1'b1);
  endtask

  task automatic test_pause_until_drained();
    send_text("x/y");
    wait_for_drain();
    send_text("z");
  endtask

  task automatic test_random_text(input int count);
    int stop_at;
    stop_at = sent_count + count;
    while (sent_count < stop_at) send_random_token();
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
    if (rst_n && out_valid && !out_stall) begin
      if (expected_tokens.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: kind %0d char %02h line %0d col %0d",
                   out_kind, out_char_out, out_line_no, out_column_no);
      end else begin
        head_token = expected_tokens.pop_front();
        if (out_kind !== head_token.kind || out_char_out !== head_token.ch ||
            out_line_no !== head_token.line || out_column_no !== head_token.col) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected kind %0d char %02h line %0d col %0d,",
                     head_token.kind, head_token.ch, head_token.line, head_token.col,
                     " got kind %0d char %02h line %0d col %0d",
                     out_kind, out_char_out, out_line_no, out_column_no);
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 21;
    recv_idle_pct = 60;
    test_visible_extremes();
    test_whitespace();
    test_comments();
    test_stray_slash_and_end();
    test_pause_until_drained();
    test_random_text(560);
    send_idle_pct = 60;
    recv_idle_pct = 21;
    test_random_text(560);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_text(560);
    wait_for_drain();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_tokens.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
